// ===== design/pfta_pkg.sv =====
// Shared types and constants for the pair fixed-point transform ALU.
// Used by the register file, the serial lane datapath and the top level.
// No dependencies.
package pfta_pkg;

    // Default sizes of the datapath
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 24;

    // Configured operation
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_MUL    = 2'd1,
        OP_ROOT   = 2'd2,
        OP_SQUARE = 2'd3
    } op_t;

    // Register index on the configuration port
    typedef enum logic [1:0] {
        REG_OPERATION = 2'd0,
        REG_LANE_A    = 2'd1,
        REG_LANE_B    = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

    // Result status
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NEG_A = 2'd1,
        STAT_NEG_B = 2'd2
    } status_t;

    // Sequencer state
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    // Decoded configuration handed to the sequencer
    typedef struct packed {
        op_t  op;
        logic en_a;
        logic en_b;
    } cfg_flags_t;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
        op_t  op;
        logic apply;
    } lane_ctl_t;

endpackage

// ===== design/pfta_cfg.sv =====
// Configuration register file with an APB-style write/read port.
// Also derives the lane enables (operand magnitude above threshold).
// Depends on pfta_pkg.
module pfta_cfg
    import pfta_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [((DATA_WIDTH > 32) ? 5 : 4)-1:0] paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                  pready,
    output cfg_flags_t                            flags,
    output logic [DATA_WIDTH-1:0]                 opnd_a,
    output logic [DATA_WIDTH-1:0]                 opnd_b
);

    localparam int ASH    = (DATA_WIDTH > 32) ? 3 : 2;
    localparam int ADDR_W = ASH + 2;
    localparam int PDW    = (DATA_WIDTH > 32) ? 64 : 32;

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] opa_reg;
    logic [DATA_WIDTH-1:0] opb_reg;
    logic [DATA_WIDTH-2:0] thr_reg;
    logic                  en_a_reg;
    logic                  en_b_reg;

    reg_idx_t              reg_idx;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ASH]);
    assign wr_en   = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= OP_ADD;
            opa_reg <= '0;
            opb_reg <= '0;
            thr_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OPERATION: op_reg  <= op_t'(pwdata[1:0]);
                REG_LANE_A:    opa_reg <= pwdata[DATA_WIDTH-1:0];
                REG_LANE_B:    opb_reg <= pwdata[DATA_WIDTH-1:0];
                REG_THRESHOLD: thr_reg <= pwdata[DATA_WIDTH-2:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_OPERATION: prdata = PDW'(op_reg);
            REG_LANE_A:    prdata = PDW'(opa_reg);
            REG_LANE_B:    prdata = PDW'(opb_reg);
            REG_THRESHOLD: prdata = PDW'(thr_reg);
        endcase
    end

    // Operand magnitudes; the most negative value maps to 2^(DATA_WIDTH-1)
    assign mag_a = opa_reg[DATA_WIDTH-1] ? (~opa_reg + 1'b1) : opa_reg;
    assign mag_b = opb_reg[DATA_WIDTH-1] ? (~opb_reg + 1'b1) : opb_reg;

    // Register the lane enables; they are only read at the end of an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_a_reg <= 1'b0;
            en_b_reg <= 1'b0;
        end
        else
        begin
            en_a_reg <= mag_a > {1'b0, thr_reg};
            en_b_reg <= mag_b > {1'b0, thr_reg};
        end
    end

    assign flags.op   = op_reg;
    assign flags.en_a = en_a_reg;
    assign flags.en_b = en_b_reg;
    assign opnd_a     = opa_reg;
    assign opnd_b     = opb_reg;

endmodule

// ===== design/pfta_lane.sv =====
// Serial datapath for one lane: bit-serial add, shift-add multiply and
// restoring square root, two radicand bits per step, plus result saturation.
// Depends on pfta_pkg.
module pfta_lane
    import pfta_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  lane_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] x_in,
    input  logic [DATA_WIDTH-1:0] opnd,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  x_neg
);

    localparam int DW   = DATA_WIDTH;
    localparam int RB   = (DATA_WIDTH + FRAC_BITS) / 2;
    localparam int RS   = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int RADW = 2 * RS;
    localparam int REMW = RS + 2;
    localparam int XW   = 2 * DATA_WIDTH + FRAC_BITS;
    localparam int CW   = (RS > DATA_WIDTH) ? RS : DATA_WIDTH;

    localparam logic [DW-1:0] VMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [CW:0]   ONE_W = 1;
    localparam logic [CW:0]   CAP_W = (RB < DATA_WIDTH - 1) ? ((ONE_W << RB) - ONE_W)
                                      : ((ONE_W << (DATA_WIDTH - 1)) - ONE_W);
    localparam logic [CW-1:0] ROOT_CAP = CAP_W[CW-1:0];

    logic [DW-1:0]   x_reg,     x_next;
    logic [DW-1:0]   lo_reg,    lo_next;
    logic [DW-1:0]   hi_reg,    hi_next;
    logic [DW-1:0]   mcand_reg, mcand_next;
    logic            carry_reg, carry_next;
    logic            pneg_reg,  pneg_next;
    logic [RADW-1:0] rad_reg,   rad_next;
    logic [REMW-1:0] rem_reg,   rem_next;
    logic [RS-1:0]   root_reg,  root_next;

    logic [DW-1:0]   x_mag;
    logic [DW-1:0]   opnd_mag;
    logic [DW:0]     mac_sum;
    logic            add_bit;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            root_fit;

    logic [XW-1:0]   px;
    logic [DW-1:0]   q_low;
    logic            sticky;
    logic            q_ge;
    logic            q_upper;
    logic            q_eq_top;
    logic [DW-1:0]   mul_res;
    logic            add_ovf;
    logic [DW-1:0]   add_res;
    logic [CW-1:0]   root_ext;
    logic [DW-1:0]   root_res;

    assign x_mag    = x_in[DW-1] ? (~x_in + 1'b1) : x_in;
    assign opnd_mag = opnd[DW-1] ? (~opnd + 1'b1) : opnd;

    // Per-step arithmetic
    assign mac_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign add_bit  = lo_reg[0] ^ hi_reg[0] ^ carry_reg;
    assign rem_sh   = {rem_reg[RS-1:0], rad_reg[RADW-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_fit = rem_sh >= trial;

    // Load on accept, advance one digit per step
    always_comb
    begin
        x_next     = x_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mcand_next = mcand_reg;
        carry_next = carry_reg;
        pneg_next  = pneg_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        if (ctl.load)
        begin
            x_next     = x_in;
            lo_next    = (ctl.op == OP_ADD) ? x_in : x_mag;
            hi_next    = (ctl.op == OP_ADD) ? opnd : '0;
            mcand_next = (ctl.op == OP_SQUARE) ? x_mag : opnd_mag;
            pneg_next  = (ctl.op == OP_SQUARE) ? 1'b0 : (x_in[DW-1] ^ opnd[DW-1]);
            carry_next = 1'b0;
            rad_next   = RADW'(x_in) << FRAC_BITS;
            rem_next   = '0;
            root_next  = '0;
        end
        else if (ctl.step)
        begin
            unique case (ctl.op)
                OP_ADD:
                begin
                    lo_next    = {add_bit, lo_reg[DW-1:1]};
                    hi_next    = hi_reg >> 1;
                    carry_next = (lo_reg[0] & hi_reg[0]) | (carry_reg & (lo_reg[0] ^ hi_reg[0]));
                end
                OP_MUL, OP_SQUARE:
                begin
                    hi_next = mac_sum[DW:1];
                    lo_next = {mac_sum[0], lo_reg[DW-1:1]};
                end
                OP_ROOT:
                begin
                    rem_next  = root_fit ? (rem_sh - trial) : rem_sh;
                    root_next = {root_reg[RS-2:0], root_fit};
                    rad_next  = rad_reg << 2;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mcand_reg <= mcand_next;
        carry_reg <= carry_next;
        pneg_reg  <= pneg_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
    end

    // Product: drop fraction bits, round toward minus infinity, saturate
    assign px       = XW'({hi_reg, lo_reg});
    assign q_low    = px[DATA_WIDTH+FRAC_BITS-1:FRAC_BITS];
    assign sticky   = |px[FRAC_BITS-1:0];
    assign q_ge     = |px[XW-1:DATA_WIDTH+FRAC_BITS-1];
    assign q_upper  = |px[XW-1:DATA_WIDTH+FRAC_BITS];
    assign q_eq_top = q_low[DW-1] && !q_upper && !(|q_low[DW-2:0]);

    always_comb
    begin
        if (pneg_reg)
        begin
            if ((q_ge && !q_eq_top) || (q_eq_top && sticky))
                mul_res = VMIN;
            else
                mul_res = ~q_low + DW'(!sticky);
        end
        else
        begin
            mul_res = q_ge ? VMAX : q_low;
        end
    end

    // Sum: saturate on signed overflow
    assign add_ovf = (x_reg[DW-1] == opnd[DW-1]) && (lo_reg[DW-1] != x_reg[DW-1]);
    assign add_res = add_ovf ? (x_reg[DW-1] ? VMIN : VMAX) : lo_reg;

    // Root: clamp to the root width and to the largest positive value
    assign root_ext = CW'(root_reg);
    assign root_res = (root_ext > ROOT_CAP) ? ROOT_CAP[DW-1:0] : root_ext[DW-1:0];

    // Pick the lane result; a lane that is not applied passes unchanged
    always_comb
    begin
        unique case (ctl.op)
            OP_ADD:    result = add_res;
            OP_MUL:    result = mul_res;
            OP_SQUARE: result = ctl.apply ? mul_res : x_reg;
            OP_ROOT:   result = ctl.apply ? root_res : x_reg;
        endcase
    end

    assign x_neg = x_reg[DW-1];

endmodule

// ===== design/pair_fixed_point_transform_alu_top.sv =====
// Top level of the pair fixed-point transform ALU: sequencer, failure counter
// and output register. Instantiates pfta_cfg and two pfta_lane; uses pfta_pkg.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------------
//   s_axis    | s_axis_tvalid/tready      | tdata: lane_a_in, lane_b_in; tlast
//   m_axis    | m_axis_tvalid/tready      | tdata: lane_a_out, lane_b_out, status,
//             |                           |        failures_so_far; tlast
//   apb       | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// An item is accepted in S_IDLE, stepped in S_RUN and parked in the output register
// from S_FIN. Both lanes work in parallel; the serial step count of the lane datapath
// sets how long an item takes, and add, multiply and square take more steps than square
// root at the default sizes. The next request is taken only after the result is parked,
// so one item is in flight at a time. Reset clears the sequencer, the registers and the
// failure counter; a stalled output holds the sequencer until it drains.
module pair_fixed_point_transform_alu_top
    import pfta_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    // input request
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [DATA_WIDTH-1:0] lane_a_in, [2*DATA_WIDTH-1:DATA_WIDTH] lane_b_in, zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                      s_axis_tlast,
    // result request
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // lane_a_out, lane_b_out, status (2), failures_so_far (COUNT_WIDTH), zero pad
    output logic [((2*DATA_WIDTH+2+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                                      m_axis_tlast,
    // configuration
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [((DATA_WIDTH > 32) ? 5 : 4)-1:0]    paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0]  pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0]  prdata,
    output logic                                      pready
);

    localparam int OUT_W     = ((2*DATA_WIDTH + 2 + COUNT_WIDTH + 7) / 8) * 8;
    localparam int RS        = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int STEPS_MAX = (RS > DATA_WIDTH) ? RS : DATA_WIDTH;
    localparam int CNTW      = $clog2(STEPS_MAX);

    localparam logic [CNTW-1:0]        LAST_SERIAL = CNTW'(DATA_WIDTH - 1);
    localparam logic [CNTW-1:0]        LAST_ROOT   = CNTW'(RS - 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX        = '1;

    state_t                 state_reg, state_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] fail_reg, fail_next;
    logic                   last_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg;
    logic                   m_last_reg;

    cfg_flags_t             flags;
    logic [DATA_WIDTH-1:0]  opnd_a;
    logic [DATA_WIDTH-1:0]  opnd_b;
    lane_ctl_t              ctl_a;
    lane_ctl_t              ctl_b;
    logic [DATA_WIDTH-1:0]  res_a;
    logic [DATA_WIDTH-1:0]  res_b;
    logic                   neg_a;
    logic                   neg_b;

    logic                   lane_load;
    logic                   lane_step;
    logic                   out_load;
    logic                   out_free;
    logic                   step_last;
    status_t                stat;
    logic                   apply_a;
    logic                   apply_b;
    logic [COUNT_WIDTH-1:0] fail_inc;

    pfta_cfg #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .flags   (flags),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b)
    );

    pfta_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_a (
        .clk    (clk),
        .ctl    (ctl_a),
        .x_in   (s_axis_tdata[DATA_WIDTH-1:0]),
        .opnd   (opnd_a),
        .result (res_a),
        .x_neg  (neg_a)
    );

    pfta_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_b (
        .clk    (clk),
        .ctl    (ctl_b),
        .x_in   (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .opnd   (opnd_b),
        .result (res_b),
        .x_neg  (neg_b)
    );

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign step_last = cnt_reg == ((flags.op == OP_ROOT) ? LAST_ROOT : LAST_SERIAL);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (step_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        lane_load     = 1'b0;
        lane_step     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                lane_load     = s_axis_tvalid;
            end
            S_RUN:
            begin
                lane_step = 1'b1;
            end
            S_FIN:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // Status: a negative enabled lane blocks the root, lane A first
    always_comb
    begin
        priority if (flags.op == OP_ROOT && flags.en_a && neg_a)
            stat = STAT_NEG_A;
        else if (flags.op == OP_ROOT && flags.en_b && neg_b)
            stat = STAT_NEG_B;
        else
            stat = STAT_OK;
    end

    // Lane apply: add and multiply always act, the rest only on enabled lanes (root also only with status OK)
    always_comb
    begin
        unique case (flags.op)
            OP_ADD, OP_MUL:
            begin
                apply_a = 1'b1;
                apply_b = 1'b1;
            end
            OP_SQUARE:
            begin
                apply_a = flags.en_a;
                apply_b = flags.en_b;
            end
            OP_ROOT:
            begin
                apply_a = flags.en_a && (stat == STAT_OK);
                apply_b = flags.en_b && (stat == STAT_OK);
            end
        endcase
    end

    assign ctl_a.load  = lane_load;
    assign ctl_a.step  = lane_step;
    assign ctl_a.op    = flags.op;
    assign ctl_a.apply = apply_a;
    assign ctl_b.load  = lane_load;
    assign ctl_b.step  = lane_step;
    assign ctl_b.op    = flags.op;
    assign ctl_b.apply = apply_b;

    // Failure count including this item, held at its largest value
    assign fail_inc = ((stat != STAT_OK) && (fail_reg != CMAX)) ? (fail_reg + 1'b1) : fail_reg;

    // Step counter, failure counter and output valid
    always_comb
    begin
        cnt_next     = cnt_reg;
        fail_next    = fail_reg;
        m_valid_next = m_valid_reg;
        if (lane_load)
            cnt_next = '0;
        else if (lane_step)
            cnt_next = cnt_reg + 1'b1;
        if (out_load)
        begin
            fail_next    = last_reg ? '0 : fail_inc;
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fail_reg    <= fail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the frame mark of the item in flight and the parked result
    always_ff @(posedge clk)
    begin
        if (lane_load)
            last_reg <= s_axis_tlast;
        if (out_load)
        begin
            m_data_reg <= OUT_W'({fail_inc, 2'(stat), res_b, res_a});
            m_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== bench/tb_pair_fixed_point_transform_alu_top.sv =====
`timescale 1ns / 100ps
// Testbench for pair_fixed_point_transform_alu_top: directed and random elements checked
// against an in-bench predictor of the add, multiply, root and square transforms.
// Depends on pfta_pkg and the design files under design/.
module tb_pair_fixed_point_transform_alu_top;
    import pfta_pkg::*;

    localparam int     DW        = DATA_WIDTH_DEF;
    localparam int     FB        = FRAC_BITS_DEF;
    localparam int     CW        = COUNT_WIDTH_DEF;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam int     SETTLE    = 40;
    localparam int     RAND_ELEMS = 1900;

    typedef struct {
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [1:0]    status;
        logic [CW-1:0] failures;
        logic          last;
    } element_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // lane_a_in [31:0], lane_b_in [63:32]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // lane_a_out [31:0], lane_b_out [63:32], status [65:64], failures_so_far [89:66], pad
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the registers and the failure counter
    op_t                cfg_op = OP_ADD;
    logic signed [31:0] cfg_a_operand = '0;
    logic signed [31:0] cfg_b_operand = '0;
    logic [30:0]        cfg_threshold = '0;
    logic [CW-1:0]      failure_tally = '0;

    element_result_t    pending_results[$];
    int                 mismatch_count = 0;
    int                 results_checked = 0;
    int                 elements_sent = 0;
    int                 reg_writes = 0;
    int                 root_failures = 0;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 stall_mode = 0;
    int                 stall_phase = 0;

    pair_fixed_point_transform_alu_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] saturate(longint value);
        if (value > Q_MAX)
            return 32'h7FFF_FFFF;
        if (value < Q_MIN)
            return 32'h8000_0000;
        return value[31:0];
    endfunction

    function automatic logic [31:0] sat_add(logic signed [31:0] x, logic signed [31:0] y);
        return saturate(longint'(x) + longint'(y));
    endfunction

    // Full product shifted down with floor rounding
    function automatic logic [31:0] fixed_mul(logic signed [31:0] x, logic signed [31:0] y);
        longint product;
        product = longint'(x) * longint'(y);
        return saturate(product >>> FB);
    endfunction

    // floor(sqrt(x * 2^FB)) found one bit at a time, x non-negative
    function automatic logic [31:0] fixed_root(logic [31:0] x);
        bit [63:0] radicand;
        bit [63:0] root;
        bit [63:0] trial;
        radicand = {16'd0, x, 16'd0};
        root = '0;
        for (int i = (DW + FB) / 2 - 1; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root[31:0];
    endfunction

    function automatic bit lane_enabled(logic signed [31:0] operand);
        logic [32:0] mag;
        mag = operand[31] ? (33'd0 - {operand[31], operand}) : {1'b0, operand};
        return mag > {2'b00, cfg_threshold};
    endfunction

    function automatic element_result_t transform_element(logic signed [31:0] a,
                                                          logic signed [31:0] b,
                                                          logic last);
        element_result_t res;
        bit en_a;
        bit en_b;
        status_t st;
        en_a = lane_enabled(cfg_a_operand);
        en_b = lane_enabled(cfg_b_operand);
        st = STAT_OK;
        res.a = a;
        res.b = b;
        case (cfg_op)
            OP_ADD:
            begin
                res.a = sat_add(a, cfg_a_operand);
                res.b = sat_add(b, cfg_b_operand);
            end
            OP_MUL:
            begin
                res.a = fixed_mul(a, cfg_a_operand);
                res.b = fixed_mul(b, cfg_b_operand);
            end
            OP_ROOT:
            begin
                if (en_a && a[31])
                    st = STAT_NEG_A;
                else if (en_b && b[31])
                    st = STAT_NEG_B;
                else
                begin
                    if (en_a)
                        res.a = fixed_root(a);
                    if (en_b)
                        res.b = fixed_root(b);
                end
            end
            default:
            begin
                if (en_a)
                    res.a = fixed_mul(a, a);
                if (en_b)
                    res.b = fixed_mul(b, b);
            end
        endcase
        // count the failure, saturating, and clear at the end of the data set
        if (st != STAT_OK && failure_tally != {CW{1'b1}})
            failure_tally = failure_tally + 1'b1;
        res.status = st;
        res.failures = failure_tally;
        res.last = last;
        if (last)
            failure_tally = '0;
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_OPERATION: cfg_op = op_t'(value[1:0]);
            REG_LANE_A:    cfg_a_operand = value;
            REG_LANE_B:    cfg_b_operand = value;
            default:       cfg_threshold = value[30:0];
        endcase
        reg_writes++;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(op_t op, logic [31:0] a_operand, logic [31:0] b_operand,
                             logic [30:0] threshold);
        write_reg(REG_OPERATION, {30'd0, op});
        write_reg(REG_LANE_A, a_operand);
        write_reg(REG_LANE_B, b_operand);
        write_reg(REG_THRESHOLD, {1'b0, threshold});
    endtask

    // Send one element; the sender runs in bursts with random gaps between them
    task automatic send_element(logic [31:0] a, logic [31:0] b, logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tdata = {b, a};
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(transform_element(a, b, last));
        if (cfg_op == OP_ROOT && pending_results[$].status != STAT_OK)
            root_failures++;
        elements_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Receiver stalls: modes of random length, from always ready to mostly stalled
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        stall_phase = (stall_phase + 1) % 8;
        case (stall_mode)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = 1'($urandom_range(0, 1));
            2:       m_axis_tready = ($urandom_range(0, 3) == 0);
            default: m_axis_tready = (stall_phase < 5);
        endcase
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        element_result_t want;
        logic [31:0] got_a;
        logic [31:0] got_b;
        logic [1:0]  got_status;
        logic [CW-1:0] got_failures;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_a = m_axis_tdata[31:0];
            got_b = m_axis_tdata[63:32];
            got_status = m_axis_tdata[65:64];
            got_failures = m_axis_tdata[66 +: CW];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result a=%h b=%h status=%0d failures=%0d last=%0b",
                             $time, got_a, got_b, got_status, got_failures, m_axis_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got_a !== want.a || got_b !== want.b || got_status !== want.status ||
                    got_failures !== want.failures || m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch expected a=%h b=%h status=%0d failures=%0d last=%0b",
                                 $time, want.a, want.b, want.status, want.failures, want.last);
                        $display("%0t:          actual   a=%h b=%h status=%0d failures=%0d last=%0b",
                                 $time, got_a, got_b, got_status, got_failures, m_axis_tlast);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            3:
            begin
                case ($urandom_range(0, 6))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    4:       v = 32'hFFFF_FFFF;
                    5:       v = 32'h0001_0000;
                    default: v = 32'hFFFF_0000;
                endcase
            end
            4:    v = (int'($urandom_range(0, 512)) - 256) <<< FB;
            default:
                v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1 << 16)
                                         : 32'h8000_0000 + $urandom_range(0, 1 << 16);
        endcase
        return v;
    endfunction

    function automatic logic [30:0] pick_threshold();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(0, 32'h0002_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    // Saturation at both ends of the range
    task automatic test_add_extremes();
        configure(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_element(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        drain();
        configure(OP_ADD, 32'h0001_8000, 32'hFFFF_FFFF, '0);
        send_element(32'h7FFF_0000, 32'h8000_0000, 1'b0);
        send_element(32'hFFFE_8000, 32'h0000_0001, 1'b1);
        drain();
    endtask

    // Floor rounding of small products and overflow in both signs
    task automatic test_multiply();
        configure(OP_MUL, 32'h0000_8000, 32'hFFFF_8000, '0);
        send_element(32'h0000_0001, 32'h0000_0001, 1'b0);
        send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_element(32'h0003_0000, 32'hFFFD_0000, 1'b0);
        drain();
        configure(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 32'h8000_0000, 1'b1);
        drain();
    endtask

    // Roots, negative lanes on each side, the failure count and its clear on last
    task automatic test_root();
        configure(OP_ROOT, 32'h0000_0001, 32'hFFFF_FFFF, '0);
        send_element(32'h0004_0000, 32'h0001_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_element(32'h8000_0000, 32'h0000_0005, 1'b0);
        send_element(32'h0000_0005, 32'hFFFF_FFFF, 1'b0);
        send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_element(32'h0000_0007, 32'h0000_0003, 1'b0);
        drain();
        // lane B disabled: a negative value there passes untouched
        write_reg(REG_LANE_B, 32'h0000_0000);
        send_element(32'h0000_0009, 32'hFFFF_FFFB, 1'b1);
        drain();
    endtask

    // Square on an enabled lane A only
    task automatic test_square();
        configure(OP_SQUARE, 32'h8000_0000, 32'h0000_0000, '0);
        send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 32'h0000_0003, 1'b0);
        send_element(32'hFFFF_8000, 32'h8000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();
    endtask

    // Enable decision when the operand magnitude sits at the threshold
    task automatic test_threshold_edges();
        configure(OP_ROOT, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_element(32'hFFFC_0000, 32'hFFFC_0000, 1'b0);
        drain();
        configure(OP_ROOT, 32'h0001_0000, 32'h0001_0001, 31'h0001_0000);
        send_element(32'hFFFC_0000, 32'hFFFC_0000, 1'b0);
        send_element(32'hFFFC_0000, 32'h0010_0000, 1'b1);
        drain();
    endtask

    // Random data sets under a fresh random setting per phase
    task automatic test_random_sets(int total);
        int set_left;
        int per_phase;
        logic [31:0] a_val;
        logic [31:0] b_val;
        op_t op;
        set_left = 0;
        per_phase = total / 10;
        for (int phase = 0; phase < 10; phase++)
        begin
            op = (phase < 4) ? op_t'(phase) : op_t'($urandom_range(0, 3));
            configure(op, pick_value(), pick_value(), pick_threshold());
            for (int k = 0; k < per_phase; k++)
            begin
                if (set_left == 0)
                    set_left = $urandom_range(1, 24);
                a_val = pick_value();
                b_val = pick_value();
                // mostly non-negative lanes so roots are taken, not only refused
                if (cfg_op == OP_ROOT)
                begin
                    if ($urandom_range(0, 9) < 7)
                        a_val[31] = 1'b0;
                    if ($urandom_range(0, 9) < 7)
                        b_val[31] = 1'b0;
                end
                set_left--;
                send_element(a_val, b_val, set_left == 0);
            end
            drain();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_add_extremes();
        test_multiply();
        test_root();
        test_square();
        test_threshold_edges();
        test_random_sets(RAND_ELEMS);

        $display("Sent %0d elements over add, multiply, root and square with %0d register writes;",
                 elements_sent, reg_writes);
        $display("%0d results checked, %0d refused roots, %0d mismatches.",
                 results_checked, root_failures, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
